// ===== sv/msdp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package msdp_pkg;

    localparam logic [7:0] IAC_CODE = 8'hFF;
    localparam logic [7:0] SB_CODE  = 8'hFA;
    localparam logic [7:0] SE_CODE  = 8'hF0;
    localparam logic [7:0] OPT_MSDP = 8'h45;
    localparam logic [7:0] OPT_GMCP = 8'hC9;

    localparam logic [2:0] MK_NONE   = 3'd0;
    localparam logic [2:0] MK_VAR    = 3'd1;
    localparam logic [2:0] MK_VAL    = 3'd2;
    localparam logic [2:0] MK_TOPEN  = 3'd3;
    localparam logic [2:0] MK_TCLOSE = 3'd4;
    localparam logic [2:0] MK_AOPEN  = 3'd5;
    localparam logic [2:0] MK_ACLOSE = 3'd6;

    localparam logic [7:0] NO_LOOK   = 8'h00;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam logic [3:0] HDR_LEN = 4'd9;
    localparam logic [3:0] TRL_LEN = 4'd3;

    typedef struct packed {
        logic [2:0][7:0] data;
        logic [1:0]      n;
        logic [2:0]      pm;
    } conv_t;

    typedef struct packed {
        logic            hdr;
        logic [2:0][7:0] c1_data;
        logic [1:0]      c1_n;
        logic [2:0][7:0] c2_data;
        logic [1:0]      c2_n;
        logic            trailer;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [7:0] hdr_byte(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0:    r = IAC_CODE;
            4'd1:    r = SB_CODE;
            4'd2:    r = OPT_GMCP;
            4'd3:    r = 8'h4D;
            4'd4:    r = 8'h53;
            4'd5:    r = 8'h44;
            4'd6:    r = 8'h50;
            4'd7:    r = 8'h20;
            4'd8:    r = CH_LBRACE;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] trl_byte(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = CH_RBRACE;
            2'd1:    r = IAC_CODE;
            2'd2:    r = SE_CODE;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic conv_t convert(input logic [7:0] b, input logic [7:0] look,
                                      input logic [2:0] pm);
        conv_t      r;
        logic       in_str;
        logic [1:0] n;
        in_str = (pm == MK_VAR) || (pm == MK_VAL);
        r.data = '0;
        r.pm   = pm;
        n      = 2'd0;
        case (b)
            {5'd0, MK_TOPEN}:
            begin
                r.data[0] = CH_LBRACE;
                n         = 2'd1;
                r.pm      = MK_TOPEN;
            end
            {5'd0, MK_TCLOSE}:
            begin
                if (in_str)
                begin
                    r.data[n] = CH_QUOTE;
                    n         = n + 2'd1;
                end
                r.data[n] = CH_RBRACE;
                n         = n + 2'd1;
                r.pm      = MK_TCLOSE;
            end
            {5'd0, MK_AOPEN}:
            begin
                r.data[0] = CH_LBRACK;
                n         = 2'd1;
                r.pm      = MK_AOPEN;
            end
            {5'd0, MK_ACLOSE}:
            begin
                if (in_str)
                begin
                    r.data[n] = CH_QUOTE;
                    n         = n + 2'd1;
                end
                r.data[n] = CH_RBRACK;
                n         = n + 2'd1;
                r.pm      = MK_ACLOSE;
            end
            {5'd0, MK_VAR}:
            begin
                if (in_str)
                begin
                    r.data[n] = CH_QUOTE;
                    n         = n + 2'd1;
                end
                if (in_str || pm == MK_TCLOSE || pm == MK_ACLOSE)
                begin
                    r.data[n] = CH_COMMA;
                    n         = n + 2'd1;
                end
                r.data[n] = CH_QUOTE;
                n         = n + 2'd1;
                r.pm      = MK_VAR;
            end
            {5'd0, MK_VAL}:
            begin
                if (pm == MK_VAR)
                begin
                    r.data[0] = CH_QUOTE;
                    r.data[1] = CH_COLON;
                    n         = 2'd2;
                end
                if (pm == MK_VAL)
                begin
                    r.data[0] = CH_QUOTE;
                    r.data[1] = CH_COMMA;
                    n         = 2'd2;
                end
                if (look != {5'd0, MK_TOPEN} && look != {5'd0, MK_AOPEN})
                begin
                    r.data[n] = CH_QUOTE;
                    n         = n + 2'd1;
                end
                r.pm = MK_VAL;
            end
            CH_BSLASH:
            begin
                r.data[0] = CH_BSLASH;
                r.data[1] = CH_BSLASH;
                n         = 2'd2;
            end
            CH_QUOTE:
            begin
                r.data[0] = CH_BSLASH;
                r.data[1] = CH_QUOTE;
                n         = 2'd2;
            end
            default:
            begin
                r.data[0] = b;
                n         = 2'd1;
            end
        endcase
        r.n = n;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/msdp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msdp_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    data_byte,
    input  wire logic          end_of_message,
    output msdp_pkg::job_t     job,
    output logic               enq
);

    logic [7:0] held_byte_reg, held_byte_next;
    logic       held_valid_reg, held_valid_next;
    logic [1:0] pos_reg, pos_next;
    logic [2:0] pm_reg, pm_next;
    logic       stopped_reg, stopped_next;

    msdp_pkg::conv_t c1;
    msdp_pkg::conv_t c2;

    always_comb
    begin
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        pos_next        = pos_reg;
        pm_next         = pm_reg;
        stopped_next    = stopped_reg;
        c1              = '0;
        c2              = '0;
        job             = '0;
        if (!stopped_reg)
        begin
            if (pos_reg < 2'd2)
            begin
                pos_next = pos_reg + 2'd1;
            end
            else if (pos_reg == 2'd2)
            begin
                job.hdr  = (data_byte == msdp_pkg::OPT_MSDP);
                pos_next = 2'd3;
            end
            else
            begin
                if (held_valid_reg)
                begin
                    if (held_byte_reg == msdp_pkg::IAC_CODE && data_byte == msdp_pkg::SE_CODE)
                    begin
                        stopped_next    = 1'b1;
                        held_valid_next = 1'b0;
                    end
                    else
                    begin
                        c1      = msdp_pkg::convert(held_byte_reg, data_byte, pm_reg);
                        pm_next = c1.pm;
                    end
                end
                if (!stopped_next)
                begin
                    held_byte_next  = data_byte;
                    held_valid_next = 1'b1;
                end
            end
        end
        job.c1_data = c1.data;
        job.c1_n    = c1.n;
        if (end_of_message)
        begin
            if (held_valid_next && !stopped_next)
            begin
                c2 = msdp_pkg::convert(held_byte_next, msdp_pkg::NO_LOOK, pm_next);
            end
            job.trailer     = 1'b1;
            held_byte_next  = 8'h00;
            held_valid_next = 1'b0;
            pos_next        = 2'd0;
            pm_next         = msdp_pkg::MK_NONE;
            stopped_next    = 1'b0;
        end
        job.c2_data = c2.data;
        job.c2_n    = c2.n;
    end

    // drop words that produce no output
    assign enq = accept && (job.hdr || job.c1_n != 2'd0 || job.c2_n != 2'd0 || job.trailer);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_byte_reg  <= 8'h00;
            held_valid_reg <= 1'b0;
            pos_reg        <= 2'd0;
            pm_reg         <= msdp_pkg::MK_NONE;
            stopped_reg    <= 1'b0;
        end
        else if (accept)
        begin
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            pos_reg        <= pos_next;
            pm_reg         <= pm_next;
            stopped_reg    <= stopped_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/msdp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msdp_queue
#(
    parameter int DEPTH = 4
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               enq,
    input  wire msdp_pkg::job_t     enq_job,
    input  wire logic               deq,
    output msdp_pkg::job_t          head_job,
    output msdp_pkg::q_status_t     status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    msdp_pkg::job_t   slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_job     = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (enq)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (deq)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (enq && !deq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (deq && !enq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            slots[wr_ptr_reg] <= enq_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/msdp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msdp_back
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire msdp_pkg::job_t    head_job,
    input  wire msdp_pkg::q_status_t q_status,
    output logic                   deq,
    input  wire logic              pop,
    output logic                   empty,
    output logic [7:0]             out_byte,
    output logic                   last_of_run,
    output logic                   message_done
);

    typedef enum logic [3:0]
    {
        SEG_HDR = 4'b0001,
        SEG_C1  = 4'b0010,
        SEG_C2  = 4'b0100,
        SEG_TRL = 4'b1000
    } seg_t;

    seg_t       seg_reg, seg_next;
    logic [3:0] idx_reg, idx_next;
    logic       active_reg, active_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       last_reg;
    logic       done_reg;

    seg_t       cur_seg;
    logic [3:0] cur_idx;
    logic [3:0] cur_len;
    logic [7:0] cur_byte;
    logic       cur_last;
    logic       step;
    logic       c1_any;
    logic       c2_any;

    assign c1_any = (head_job.c1_n != 2'd0);
    assign c2_any = (head_job.c2_n != 2'd0);

    always_comb
    begin
        if (active_reg)
        begin
            cur_seg = seg_reg;
            cur_idx = idx_reg;
        end
        else
        begin
            cur_idx = 4'd0;
            if (head_job.hdr)
            begin
                cur_seg = SEG_HDR;
            end
            else if (c1_any)
            begin
                cur_seg = SEG_C1;
            end
            else if (c2_any)
            begin
                cur_seg = SEG_C2;
            end
            else
            begin
                cur_seg = SEG_TRL;
            end
        end

        case (cur_seg)
            SEG_HDR:
            begin
                cur_len  = msdp_pkg::HDR_LEN;
                cur_byte = msdp_pkg::hdr_byte(cur_idx);
            end
            SEG_C1:
            begin
                cur_len  = {2'b00, head_job.c1_n};
                cur_byte = head_job.c1_data[cur_idx[1:0]];
            end
            SEG_C2:
            begin
                cur_len  = {2'b00, head_job.c2_n};
                cur_byte = head_job.c2_data[cur_idx[1:0]];
            end
            SEG_TRL:
            begin
                cur_len  = msdp_pkg::TRL_LEN;
                cur_byte = msdp_pkg::trl_byte(cur_idx[1:0]);
            end
            default:
            begin
                cur_len  = 4'd0;
                cur_byte = 8'h00;
            end
        endcase

        seg_next = cur_seg;
        idx_next = cur_idx + 4'd1;
        cur_last = 1'b0;
        if (idx_next >= cur_len)
        begin
            idx_next = 4'd0;
            case (cur_seg)
                SEG_HDR:
                begin
                    if (c1_any)
                    begin
                        seg_next = SEG_C1;
                    end
                    else if (c2_any)
                    begin
                        seg_next = SEG_C2;
                    end
                    else if (head_job.trailer)
                    begin
                        seg_next = SEG_TRL;
                    end
                    else
                    begin
                        cur_last = 1'b1;
                    end
                end
                SEG_C1:
                begin
                    if (c2_any)
                    begin
                        seg_next = SEG_C2;
                    end
                    else if (head_job.trailer)
                    begin
                        seg_next = SEG_TRL;
                    end
                    else
                    begin
                        cur_last = 1'b1;
                    end
                end
                SEG_C2:
                begin
                    if (head_job.trailer)
                    begin
                        seg_next = SEG_TRL;
                    end
                    else
                    begin
                        cur_last = 1'b1;
                    end
                end
                default:
                begin
                    cur_last = 1'b1;
                end
            endcase
        end
    end

    // advance when a job waits and the output slot is free or being taken
    assign step = !q_status.empty && (!out_valid_reg || pop);
    assign deq  = step && cur_last;

    always_comb
    begin
        active_next    = active_reg;
        out_valid_next = out_valid_reg;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        if (step)
        begin
            out_valid_next = 1'b1;
            active_next    = !cur_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_byte_reg <= cur_byte;
            last_reg     <= cur_last;
            done_reg     <= (cur_seg == SEG_TRL) && (cur_idx == 4'd2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg       <= SEG_HDR;
            idx_reg       <= 4'd0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            if (step)
            begin
                seg_reg <= seg_next;
                idx_reg <= idx_next;
            end
        end
    end

    assign empty        = !out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign last_of_run  = last_reg;
    assign message_done = done_reg;

endmodule

`default_nettype wire

// ===== sv/msdp_to_json_stream_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake         Word
// input     push / full       data_byte, end_of_message
// result    empty / pop       out_byte, last_of_run, message_done
//
// An input word is taken whenever push is high while the job queue has room.
// Results leave at one byte per cycle while the consumer keeps popping; a word
// produces 0 to 12 output bytes, at most 3 in steady conversion.
// The job queue (FIFO_DEPTH jobs) lets input and output stall separately.
// Reset is asynchronous and clears the parser state, queue and output slot.
module msdp_to_json_stream_unit
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_message,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      out_byte,
    output logic            last_of_run,
    output logic            message_done
);

    msdp_pkg::job_t      fe_job;
    msdp_pkg::job_t      head_job;
    msdp_pkg::q_status_t q_status;
    logic                in_accept;
    logic                enq;
    logic                deq;

    assign full      = q_status.full;
    assign in_accept = push && !q_status.full;

    msdp_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (in_accept),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .job            (fe_job),
        .enq            (enq)
    );

    msdp_queue
    #(
        .DEPTH (FIFO_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .enq      (enq),
        .enq_job  (fe_job),
        .deq      (deq),
        .head_job (head_job),
        .status   (q_status)
    );

    msdp_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_job     (head_job),
        .q_status     (q_status),
        .deq          (deq),
        .pop          (pop),
        .empty        (empty),
        .out_byte     (out_byte),
        .last_of_run  (last_of_run),
        .message_done (message_done)
    );

    a_enq_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        enq |-> !q_status.full)
        else $error("job queued while queue full");

    a_deq_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        deq |-> !q_status.empty)
        else $error("job dequeued from empty queue");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && message_done) |-> (last_of_run && out_byte == msdp_pkg::SE_CODE))
        else $error("message end not on final SE byte");

endmodule

`default_nettype wire
